### rtl/svpd_pkg.sv
// Shared constants, sector codes and pipeline sideband type for the SVPWM duty block.
package svpd_pkg;

    localparam int DUTY_W = 15;
    localparam int CODE_W = 3;
    localparam int TW     = 17;
    localparam int SW     = TW + 1;

    localparam logic [15:0] SQ3H_Q16 = 16'd56756;

    localparam logic [CODE_W-1:0] SEC_NONE = 3'd0;
    localparam logic [CODE_W-1:0] SEC_U1   = 3'd1;
    localparam logic [CODE_W-1:0] SEC_U2   = 3'd2;
    localparam logic [CODE_W-1:0] SEC_U12  = 3'd3;
    localparam logic [CODE_W-1:0] SEC_U3   = 3'd4;
    localparam logic [CODE_W-1:0] SEC_U13  = 3'd5;
    localparam logic [CODE_W-1:0] SEC_U23  = 3'd6;
    localparam logic [CODE_W-1:0] SEC_ALL  = 3'd7;

    typedef struct packed {
        logic [TW-1:0]     t1;
        logic [TW-1:0]     t2;
        logic [CODE_W-1:0] code;
        logic              ovm;
    } t_side;

endpackage

### rtl/space_vector_pwm_duty.sv
// Top level: seven-segment space vector PWM duty generator, fully pipelined.
//
// Takes one alpha/beta voltage pair per item and returns the three phase duties, the sector
// code and an overmodulation flag. A new item is accepted every clock cycle while the pipeline
// is not stalled; the overmodulation divider resolves one quotient bit per stage. Stalls on the
// output hold the pipeline without loss, and empty stages keep accepting input while a result
// waits.
module space_vector_pwm_duty #(
    parameter int FRAC_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // volt_alpha[15:0], volt_beta[31:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // duty_u[14:0], duty_v[29:15], duty_w[44:30], zero pad
    output logic [3:0]  o_m_tuser    // sector_code[2:0], overmodulated[3]
);

    localparam int TW     = svpd_pkg::TW;
    localparam int SW     = svpd_pkg::SW;
    localparam int QB     = FRAC_BITS + 1;
    localparam int NW     = TW + FRAC_BITS + 1;
    localparam int DW     = FRAC_BITS + 2;
    localparam int DUTY_W = svpd_pkg::DUTY_W;
    localparam int CODE_W = svpd_pkg::CODE_W;
    localparam logic [NW-1:0]     ONE_N    = {{(NW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [DW-1:0]     ONE_D    = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [DUTY_W-1:0] HALF_OUT = DUTY_W'(ONE_D >> 1);

    // ready chain
    logic w_rdy_out, w_rdy_d, w_rdy_c, w_rdy_b, w_rdy_a, w_div_rdy;

    // stage A: alpha product
    logic               r_a_vld;
    logic signed [32:0] r_a_ka;
    logic signed [15:0] r_a_b;
    logic signed [32:0] w_ka;

    assign w_ka = $signed({1'b0, svpd_pkg::SQ3H_Q16}) * $signed(i_s_tdata[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_rdy_a) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_ka <= w_ka;
            r_a_b  <= $signed(i_s_tdata[31:16]);
        end
    end

    // stage B: projections, sector code, active times
    logic                r_b_vld;
    logic [TW-1:0]       r_b_t1, r_b_t2;
    logic [CODE_W-1:0]   r_b_code;
    logic signed [34:0]  w_hb, w_p2, w_p3;
    logic signed [17:0]  w_u1, w_u2, w_u3;
    logic [CODE_W-1:0]   w_code;
    logic signed [17:0]  w_t1, w_t2;

    assign w_hb = 35'(r_a_b) <<< 15;
    assign w_p2 = -35'(r_a_ka) - w_hb + 35'sd32768;
    assign w_p3 = 35'(r_a_ka) - w_hb + 35'sd32768;
    assign w_u1 = 18'(r_a_b);
    assign w_u2 = $signed(w_p2[33:16]);
    assign w_u3 = $signed(w_p3[33:16]);
    assign w_code = {!w_u3[17] && (|w_u3), !w_u2[17] && (|w_u2), !w_u1[17] && (|w_u1)};

    always_comb begin
        w_t1 = '0;
        w_t2 = '0;
        unique case (w_code)
            svpd_pkg::SEC_U13: begin w_t1 = w_u3;  w_t2 = w_u1;  end
            svpd_pkg::SEC_U1:  begin w_t1 = -w_u3; w_t2 = -w_u2; end
            svpd_pkg::SEC_U12: begin w_t1 = w_u1;  w_t2 = w_u2;  end
            svpd_pkg::SEC_U2:  begin w_t1 = -w_u1; w_t2 = -w_u3; end
            svpd_pkg::SEC_U23: begin w_t1 = w_u2;  w_t2 = w_u3;  end
            svpd_pkg::SEC_U3:  begin w_t1 = -w_u2; w_t2 = -w_u1; end
            default: begin w_t1 = '0; w_t2 = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_rdy_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b) begin
            r_b_t1   <= w_t1[TW-1:0];
            r_b_t2   <= w_t2[TW-1:0];
            r_b_code <= w_code;
        end
    end

    // stage C: sum, overmodulation test, rounded dividend
    logic            r_c_vld;
    logic [NW-1:0]   r_c_num;
    logic [SW-1:0]   r_c_den;
    svpd_pkg::t_side r_c_side;
    logic [SW-1:0]   w_s;

    assign w_s = SW'(r_b_t1) + SW'(r_b_t2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_rdy_c) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c) begin
            r_c_num       <= (NW'(r_b_t1) << FRAC_BITS) + NW'(w_s >> 1);
            r_c_den       <= w_s;
            r_c_side.t1   <= r_b_t1;
            r_c_side.t2   <= r_b_t2;
            r_c_side.code <= r_b_code;
            r_c_side.ovm  <= NW'(w_s) > ONE_N;
        end
    end

    // divider
    logic            w_div_vld;
    logic [QB-1:0]   w_div_quo;
    svpd_pkg::t_side w_div_side;

    svpd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .o_rdy   (w_div_rdy),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_side  (r_c_side),
        .o_vld   (w_div_vld),
        .i_rdy   (w_rdy_d),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    // stage D: final active times and zero time
    logic              r_d_vld;
    logic [DW-1:0]     r_d_t1, r_d_t2, r_d_t0;
    logic [CODE_W-1:0] r_d_code;
    logic              r_d_ovm;
    logic [DW-1:0]     w_t1e, w_t2e;

    assign w_t1e = w_div_side.ovm ? DW'(w_div_quo) : DW'(w_div_side.t1);
    assign w_t2e = w_div_side.ovm ? ONE_D - DW'(w_div_quo) : DW'(w_div_side.t2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_rdy_d) begin
            r_d_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_d) begin
            r_d_t1   <= w_t1e;
            r_d_t2   <= w_t2e;
            r_d_t0   <= (ONE_D - w_t1e - w_t2e) >> 1;
            r_d_code <= w_div_side.code;
            r_d_ovm  <= w_div_side.ovm;
        end
    end

    // output stage: phase duties
    logic                r_o_vld;
    logic [DUTY_W-1:0]   r_o_du, r_o_dv, r_o_dw;
    logic [CODE_W-1:0]   r_o_code;
    logic                r_o_ovm;
    logic [DW-1:0]       w_dmax, w_dmid;
    logic [DUTY_W-1:0]   w_max, w_mid, w_min;
    logic [DUTY_W-1:0]   w_du, w_dv, w_dw;
    logic                w_ovm;

    assign w_dmax = r_d_t1 + r_d_t2 + r_d_t0;
    assign w_dmid = r_d_t2 + r_d_t0;
    assign w_max  = DUTY_W'(w_dmax);
    assign w_mid  = DUTY_W'(w_dmid);
    assign w_min  = DUTY_W'(r_d_t0);

    always_comb begin
        w_ovm = r_d_ovm;
        unique case (r_d_code)
            svpd_pkg::SEC_U13: begin w_du = w_max; w_dv = w_mid; w_dw = w_min; end
            svpd_pkg::SEC_U1:  begin w_du = w_mid; w_dv = w_max; w_dw = w_min; end
            svpd_pkg::SEC_U12: begin w_du = w_min; w_dv = w_max; w_dw = w_mid; end
            svpd_pkg::SEC_U2:  begin w_du = w_min; w_dv = w_mid; w_dw = w_max; end
            svpd_pkg::SEC_U23: begin w_du = w_mid; w_dv = w_min; w_dw = w_max; end
            svpd_pkg::SEC_U3:  begin w_du = w_max; w_dv = w_min; w_dw = w_mid; end
            default: begin
                w_du  = HALF_OUT;
                w_dv  = HALF_OUT;
                w_dw  = HALF_OUT;
                w_ovm = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_rdy_out) begin
            r_o_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_o_du   <= w_du;
            r_o_dv   <= w_dv;
            r_o_dw   <= w_dw;
            r_o_code <= r_d_code;
            r_o_ovm  <= w_ovm;
        end
    end

    assign w_rdy_out  = !r_o_vld || i_m_tready;
    assign w_rdy_d    = !r_d_vld || w_rdy_out;
    assign w_rdy_c    = !r_c_vld || w_div_rdy;
    assign w_rdy_b    = !r_b_vld || w_rdy_c;
    assign w_rdy_a    = !r_a_vld || w_rdy_b;
    assign o_s_tready = w_rdy_a;

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {3'b000, r_o_dw, r_o_dv, r_o_du};
    assign o_m_tuser  = {r_o_ovm, r_o_code};

`ifndef SYNTHESIS
    a_ovm_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[3]) |->
            (o_m_tuser[2:0] != svpd_pkg::SEC_NONE && o_m_tuser[2:0] != svpd_pkg::SEC_ALL))
        else $error("overmodulation flagged on a null sector");

    a_ovm_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[3]) |->
            (o_m_tdata[14:0] == '0 || o_m_tdata[29:15] == '0 || o_m_tdata[44:30] == '0))
        else $error("overmodulated item has no phase at zero duty");

    a_null_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2:0] == svpd_pkg::SEC_NONE) |->
            (o_m_tdata[14:0] == HALF_OUT && o_m_tdata[29:15] == HALF_OUT
             && o_m_tdata[44:30] == HALF_OUT))
        else $error("null sector did not give half duty");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output slot is empty");
`endif

endmodule

### rtl/svpd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband and stall control.
module svpd_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    output logic                                o_rdy,
    input  logic [svpd_pkg::TW+FRAC_BITS:0]     i_num,
    input  logic [svpd_pkg::SW-1:0]             i_den,
    input  svpd_pkg::t_side                     i_side,
    output logic                                o_vld,
    input  logic                                i_rdy,
    output logic [FRAC_BITS:0]                  o_quo,
    output svpd_pkg::t_side                     o_side
);

    localparam int QB = FRAC_BITS + 1;
    localparam int NW = svpd_pkg::TW + FRAC_BITS + 1;
    localparam int SW = svpd_pkg::SW;

    logic [QB-1:0]   w_rdy;
    logic [QB-1:0]   r_vld;
    logic [SW-1:0]   r_rem  [QB];
    logic [SW-1:0]   r_den  [QB];
    logic [QB-1:0]   r_lo   [QB];
    logic [QB-1:0]   r_q    [QB];
    svpd_pkg::t_side r_side [QB];

    genvar k;
    for (k = 0; k < QB; k++) begin : g_stage
        logic            in_vld;
        logic [SW-1:0]   in_rem;
        logic [SW-1:0]   in_den;
        logic [QB-1:0]   in_lo;
        logic [QB-1:0]   in_q;
        svpd_pkg::t_side in_side;
        logic            nxt_rdy;
        logic [SW:0]     w_trial;
        logic            w_ge;

        if (k == 0) begin : g_first
            assign in_vld  = i_vld;
            assign in_rem  = SW'(i_num[NW-1:QB]);
            assign in_den  = i_den;
            assign in_lo   = i_num[QB-1:0];
            assign in_q    = '0;
            assign in_side = i_side;
        end else begin : g_next
            assign in_vld  = r_vld[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_den  = r_den[k-1];
            assign in_lo   = r_lo[k-1];
            assign in_q    = r_q[k-1];
            assign in_side = r_side[k-1];
        end

        if (k == QB - 1) begin : g_last
            assign nxt_rdy = i_rdy;
        end else begin : g_mid
            assign nxt_rdy = w_rdy[k+1];
        end

        assign w_rdy[k] = !r_vld[k] || nxt_rdy;
        assign w_trial  = {in_rem, in_lo[QB-1]};
        assign w_ge     = w_trial >= {1'b0, in_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k]) begin
                r_rem[k]  <= w_ge ? SW'(w_trial - {1'b0, in_den}) : w_trial[SW-1:0];
                r_den[k]  <= in_den;
                r_lo[k]   <= in_lo << 1;
                r_q[k]    <= {in_q[QB-2:0], w_ge};
                r_side[k] <= in_side;
            end
        end
    end

    assign o_rdy  = w_rdy[0];
    assign o_vld  = r_vld[QB-1];
    assign o_quo  = r_q[QB-1];
    assign o_side = r_side[QB-1];

endmodule

### tb/sv/tb.sv
// Self-checking testbench for space_vector_pwm_duty: predicts duties, sector and flag per item.
`timescale 1ns / 100ps

module tb;

    localparam int     FRAC_BITS      = 14;
    localparam longint ONE            = longint'(1) << FRAC_BITS;
    localparam int     RX_HOLD_CYCLES = 300;
    localparam int     CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [svpd_pkg::DUTY_W-1:0] u;
        logic [svpd_pkg::DUTY_W-1:0] v;
        logic [svpd_pkg::DUTY_W-1:0] w;
        logic [svpd_pkg::CODE_W-1:0] code;
        logic                        ovm;
    } t_duty;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // volt_alpha[15:0], volt_beta[31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // duty_u[14:0], duty_v[29:15], duty_w[44:30], zero pad
    logic [3:0]  m_tuser;         // sector_code[2:0], overmodulated[3]

    t_duty expected_duties[$];
    int    n_errors     = 0;
    int    cycle_count  = 0;
    int    tx_idle_pct  = 0;
    int    rx_idle_pct  = 0;
    int    rx_hold_reqs = 0;
    int    rx_hold_seen = 0;
    int    rx_hold_left = 0;

    space_vector_pwm_duty #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_duty svm_duties(input logic signed [15:0] alpha,
                                         input logic signed [15:0] beta);
        longint sa, sb, ka, hb, u1, u2, u3, t1, t2, t0, s, du, dv, dw;
        logic [svpd_pkg::CODE_W-1:0] code;
        t_duty r;
        sa = alpha;
        sb = beta;
        ka = longint'(svpd_pkg::SQ3H_Q16) * sa;
        hb = sb * 32768;
        u1 = sb;
        u2 = (-ka - hb + 32768) >>> 16;
        u3 = (ka - hb + 32768) >>> 16;
        code = {u3 > 0, u2 > 0, u1 > 0};
        t1 = 0;
        t2 = 0;
        r.ovm = 1'b0;
        case (code)
            svpd_pkg::SEC_U13: begin t1 = u3;  t2 = u1;  end
            svpd_pkg::SEC_U1:  begin t1 = -u3; t2 = -u2; end
            svpd_pkg::SEC_U12: begin t1 = u1;  t2 = u2;  end
            svpd_pkg::SEC_U2:  begin t1 = -u1; t2 = -u3; end
            svpd_pkg::SEC_U23: begin t1 = u2;  t2 = u3;  end
            svpd_pkg::SEC_U3:  begin t1 = -u2; t2 = -u1; end
            default: ;
        endcase
        if (code == svpd_pkg::SEC_NONE || code == svpd_pkg::SEC_ALL) begin
            du = ONE / 2;
            dv = ONE / 2;
            dw = ONE / 2;
        end else begin
            s = t1 + t2;
            if (s > ONE) begin
                t1 = (t1 * ONE + s / 2) / s;
                t2 = ONE - t1;
                r.ovm = 1'b1;
            end
            t0 = (ONE - t1 - t2) / 2;
            case (code)
                svpd_pkg::SEC_U13: begin du = t1 + t2 + t0; dv = t2 + t0;      dw = t0;      end
                svpd_pkg::SEC_U1:  begin du = t2 + t0;      dv = t1 + t2 + t0; dw = t0;      end
                svpd_pkg::SEC_U12: begin du = t0;           dv = t1 + t2 + t0; dw = t2 + t0; end
                svpd_pkg::SEC_U2:  begin du = t0;      dv = t2 + t0; dw = t1 + t2 + t0;      end
                svpd_pkg::SEC_U23: begin du = t2 + t0; dv = t0;      dw = t1 + t2 + t0;      end
                default: begin du = t1 + t2 + t0; dv = t0; dw = t2 + t0; end
            endcase
        end
        r.u = svpd_pkg::DUTY_W'(du);
        r.v = svpd_pkg::DUTY_W'(dv);
        r.w = svpd_pkg::DUTY_W'(dw);
        r.code = code;
        return r;
    endfunction

    // caller sits just after a rising edge; returns at the edge that accepted the item
    task automatic send_pair(input int alpha, input int beta);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(beta), 16'(alpha)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_duties.push_back(svm_duties(16'(alpha), 16'(beta)));
    endtask

    task automatic tx_stop();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rx_hold_reqs != rx_hold_seen) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_duty exp_d;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_duties.size() == 0) begin
                $error("result with no item outstanding: tdata %h tuser %h", m_tdata, m_tuser);
                n_errors++;
            end else begin
                exp_d = expected_duties.pop_front();
                check_field("duty_u", exp_d.u, m_tdata[14:0]);
                check_field("duty_v", exp_d.v, m_tdata[29:15]);
                check_field("duty_w", exp_d.w, m_tdata[44:30]);
                check_field("sector_code", exp_d.code, m_tuser[2:0]);
                check_field("overmodulated", exp_d.ovm, m_tuser[3]);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // full-scale corners, all deep in overmodulation, plus the all-zero vector
    task automatic test_extremes();
        send_pair(0, 0);
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        send_pair(32767, -32768);
        send_pair(-32768, 32767);
        send_pair(32767, 0);
        send_pair(-32768, 0);
        send_pair(0, 32767);
        send_pair(0, -32768);
        tx_stop();
    endtask

    // one vector in the middle of each sector, inside the linear range
    task automatic test_sectors();
        send_pair(6928, 4000);
        send_pair(0, 8000);
        send_pair(-6928, 4000);
        send_pair(-6928, -4000);
        send_pair(0, -8000);
        send_pair(6928, -4000);
        tx_stop();
    endtask

    // rounding of the projections near zero, odd zero time, and the hexagon edge
    task automatic test_boundaries();
        send_pair(8000, 0);
        send_pair(1, 0);
        send_pair(-1, 0);
        send_pair(0, 1);
        send_pair(0, -1);
        send_pair(18918, 0);
        send_pair(18920, 0);
        send_pair(-18920, 1);
        tx_stop();
    endtask

    task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
        int a, b, pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                a = $urandom;
                b = $urandom;
            end else if (pick < 75) begin
                a = int'($urandom_range(0, 18000)) - 9000;
                b = int'($urandom_range(0, 18000)) - 9000;
            end else if (pick < 90) begin
                a = int'($urandom_range(0, 6)) - 3;
                b = int'($urandom_range(0, 6)) - 3;
            end else begin
                a = int'($urandom_range(15000, 23000));
                b = int'($urandom_range(0, 2000)) - 1000;
                if ($urandom_range(0, 1)) a = -a;
                if ($urandom_range(0, 1)) begin
                    pick = a;
                    a = b;
                    b = pick;
                end
            end
            send_pair(a, b);
        end
        tx_stop();
    endtask

    // output held off long enough that the pipeline fills and the input stalls
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_reqs++;
        repeat (80) send_pair($urandom, $urandom);
        tx_stop();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_sectors();
        test_boundaries();
        test_random(600, 37, 67);
        test_random(600, 67, 37);
        test_random(450, 0, 0);
        test_backpressure();
        while (expected_duties.size() != 0) @(posedge clk);
        repeat (FRAC_BITS + 16) @(posedge clk);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
rtl/svpd_pkg.sv
rtl/svpd_div.sv
rtl/space_vector_pwm_duty.sv
tb/sv/tb.sv
